// File: hdl/dmtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmtl_pkg;

    // Line buffer depth and layout constants.
    localparam int LINE_CHARS_DEF = 8;
    localparam int MAX_GLYPHS     = 8;
    localparam logic [7:0] BAR_CODE   = 8'd124;
    localparam logic [7:0] PITCH      = 8'd6;
    localparam logic [3:0] GLYPH_ROWS = 4'd7;
    localparam logic [2:0] LAST_ROW   = 3'd6;
    localparam logic [3:0] INDEX_MAX  = 4'd15;

    // Division by six of an 8-bit value: (x * 171) >> 10.
    localparam logic [7:0] DIV6_MUL   = 8'd171;

    // Register reset values.
    localparam logic [7:0] RST_GRID_COLUMNS = 8'd64;
    localparam logic [5:0] RST_GRID_ROWS    = 6'd16;
    localparam logic [4:0] RST_SIDE_MARGIN  = 5'd1;
    localparam logic [2:0] RST_LINE_GAP     = 3'd1;
    localparam logic       RST_CENTRE_TEXT  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_MARGIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_GAP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTRE_TEXT  = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       text_end;
    } t_in_beat;

    typedef struct packed {
        logic [5:0] lamp_row;
        logic [7:0] first_column;
        logic [4:0] dot_mask;
        logic       run_last;
    } t_out_beat;

    // Seven 5-bit dot rows of one glyph, row 0 at index 0.
    typedef logic [6:0][4:0] t_glyph_rows;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAYOUT,
        ST_PLACE,
        ST_SCAN,
        ST_EMIT,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: hdl/dot_matrix_text_layout_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Dot matrix text layout: a 5x7 character generator for a lamp panel.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one character
// per beat. A bar character or text_end closes the line, which is then laid
// out and sent on the output channel (o_out_valid / i_out_stall /
// o_out_data), seven row beats per shown known glyph, top row first, with
// run_last set on the final beat caused by the closing character.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// is meant to be written only while the block is idle.
// A character that does not close a line leaves the block idle and ready
// for the next character. A line close runs a small sequencer: LAYOUT works
// out the row offset and glyph capacity, PLACE the start column, SCAN steps
// through each shown glyph slot, EMIT sends the seven rows of each known
// glyph, one beat per row; a last SCAN step follows and FINISH clears the line.
// The input stays stalled until the flush is done. A stalled output holds
// its beat in the output register and the sequencer waits on it.
// Reset sets the configuration registers to their defaults, empties the line
// and returns to the first text line.

module dot_matrix_text_layout_top #(
    parameter int LINE_CHARS = dmtl_pkg::LINE_CHARS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire dmtl_pkg::t_in_beat                   i_in_data,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      dmtl_pkg::t_out_beat                  o_out_data,
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [dmtl_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [7:0]                           i_cfg_data
);

    localparam int IW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam logic [3:0] LEN_MAX = 4'(LINE_CHARS);

    dmtl_pkg::t_state r_state, n_state;

    logic [7:0] r_cfg_cols;
    logic [5:0] r_cfg_rows;
    logic [4:0] r_cfg_margin;
    logic [2:0] r_cfg_gap;
    logic       r_cfg_centre;

    logic [7:0]            r_buf [LINE_CHARS];
    logic [LINE_CHARS-1:0] r_known;
    logic [3:0]            r_len, n_len;
    logic [3:0]            r_index, n_index;
    logic                  r_last, n_last;
    logic [7:0]            r_offset, n_offset;
    logic [5:0]            r_max, n_max;
    logic                  r_below, n_below;
    logic [3:0]            r_shown, n_shown;
    logic [7:0]            r_col, n_col;
    logic [3:0]            r_glyph, n_glyph;
    logic [2:0]            r_row, n_row;

    logic                  r_out_valid;
    dmtl_pkg::t_out_beat   r_out_data;

    logic                  w_in_accept;
    logic                  w_is_bar;
    logic                  w_store;
    logic                  w_known_wr;
    dmtl_pkg::t_glyph_rows w_rows_wr;
    logic [IW-1:0]         w_rd_addr;
    logic                  w_known_rd;
    dmtl_pkg::t_glyph_rows w_rows_rd;
    logic                  w_out_free;
    logic                  w_load;

    logic [3:0]  w_line_pitch;
    logic [7:0]  w_offset;
    logic [5:0]  w_twice;
    logic [7:0]  w_usable;
    logic [7:0]  w_usable_c;
    logic [15:0] w_div;
    logic [8:0]  w_bottom;
    logic [5:0]  w_len6;
    logic [5:0]  w_fit;
    logic [3:0]  w_shown;
    logic [5:0]  w_spare;
    logic [4:0]  w_half;
    logic [7:0]  w_centre_cols;
    logic [7:0]  w_start;
    logic [7:0]  w_row_sum;
    logic [4:0]  w_keep;
    logic        w_more;

    // Configuration writes; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols   <= dmtl_pkg::RST_GRID_COLUMNS;
            r_cfg_rows   <= dmtl_pkg::RST_GRID_ROWS;
            r_cfg_margin <= dmtl_pkg::RST_SIDE_MARGIN;
            r_cfg_gap    <= dmtl_pkg::RST_LINE_GAP;
            r_cfg_centre <= dmtl_pkg::RST_CENTRE_TEXT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dmtl_pkg::CFG_GRID_COLUMNS: r_cfg_cols   <= i_cfg_data;
                dmtl_pkg::CFG_GRID_ROWS:    r_cfg_rows   <= i_cfg_data[5:0];
                dmtl_pkg::CFG_SIDE_MARGIN:  r_cfg_margin <= i_cfg_data[4:0];
                dmtl_pkg::CFG_LINE_GAP:     r_cfg_gap    <= i_cfg_data[2:0];
                dmtl_pkg::CFG_CENTRE_TEXT:  r_cfg_centre <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input side: characters are taken only while the sequencer is idle.
    assign o_in_stall  = (r_state != dmtl_pkg::ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_is_bar    = (i_in_data.char_code == dmtl_pkg::BAR_CODE);
    assign w_store     = w_in_accept && !w_is_bar && (r_len < LEN_MAX);

    dmtl_font u_font_wr (
        .i_code  (i_in_data.char_code),
        .o_known (w_known_wr),
        .o_rows  (w_rows_wr)
    );

    // Line buffer with a known-glyph flag per slot.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_buf[r_len[IW-1:0]]   <= i_in_data.char_code;
            r_known[r_len[IW-1:0]] <= w_known_wr;
        end
    end

    assign w_rd_addr = (r_glyph < LEN_MAX) ? r_glyph[IW-1:0] : '0;

    dmtl_font u_font_rd (
        .i_code  (r_buf[w_rd_addr]),
        .o_known (w_known_rd),
        .o_rows  (w_rows_rd)
    );

    // Line geometry: row offset, usable width and glyph capacity.
    assign w_line_pitch = dmtl_pkg::GLYPH_ROWS + {1'b0, r_cfg_gap};
    assign w_offset     = 8'({4'b0, r_index} * {4'b0, w_line_pitch});
    assign w_twice      = {r_cfg_margin, 1'b0};
    assign w_usable     = (r_cfg_cols > {2'b0, w_twice}) ? r_cfg_cols - {2'b0, w_twice}
                                                          : 8'd0;
    assign w_usable_c   = (w_usable < dmtl_pkg::PITCH) ? dmtl_pkg::PITCH : w_usable;
    assign w_div        = {8'b0, w_usable_c} * {8'b0, dmtl_pkg::DIV6_MUL};
    assign w_bottom     = {1'b0, w_offset} + {5'b0, dmtl_pkg::GLYPH_ROWS};

    // Glyph count shown and start column.
    assign w_len6        = {2'b0, r_len};
    assign w_fit         = (w_len6 < r_max) ? w_len6 : r_max;
    assign w_shown       = (w_fit > 6'(dmtl_pkg::MAX_GLYPHS)) ? 4'(dmtl_pkg::MAX_GLYPHS)
                                                              : w_fit[3:0];
    assign w_spare       = r_max - {2'b0, w_shown};
    assign w_half        = w_spare[5:1];
    assign w_centre_cols = r_cfg_centre ? ({1'b0, w_half, 2'b0} + {2'b0, w_half, 1'b0})
                                        : 8'd0;
    assign w_start       = {3'b0, r_cfg_margin} + w_centre_cols;

    // Row beat fields: lamp row, column clip and last-beat lookahead.
    assign w_row_sum = r_offset + {5'b0, r_row};

    always_comb begin
        for (int c = 0; c < 5; c++) begin
            w_keep[4-c] = ({1'b0, r_col} + 9'(c)) < {1'b0, r_cfg_cols};
        end
    end

    always_comb begin
        w_more = 1'b0;
        for (int k = 0; k < LINE_CHARS; k++) begin
            if ((4'(k) > r_glyph) && (4'(k) < r_shown) && r_known[k]) begin
                w_more = 1'b1;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == dmtl_pkg::ST_EMIT) && w_out_free;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmtl_pkg::ST_IDLE;
            r_len   <= '0;
            r_index <= '0;
            r_last  <= 1'b0;
            r_shown <= '0;
            r_glyph <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_index <= n_index;
            r_last  <= n_last;
            r_shown <= n_shown;
            r_glyph <= n_glyph;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        r_max    <= n_max;
        r_below  <= n_below;
        r_col    <= n_col;
    end

    // Sequencer next state: layout, then one glyph slot or row per cycle while the output is not stalled.
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_index  = r_index;
        n_last   = r_last;
        n_offset = r_offset;
        n_max    = r_max;
        n_below  = r_below;
        n_shown  = r_shown;
        n_col    = r_col;
        n_glyph  = r_glyph;
        n_row    = r_row;
        case (r_state)
            dmtl_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (w_store) begin
                        n_len = r_len + 4'd1;
                    end
                    if (w_is_bar || i_in_data.text_end) begin
                        n_last  = i_in_data.text_end;
                        n_state = dmtl_pkg::ST_LAYOUT;
                    end
                end
            end
            dmtl_pkg::ST_LAYOUT: begin
                n_offset = w_offset;
                n_max    = w_div[15:10];
                n_below  = w_bottom > {3'b0, r_cfg_rows};
                n_state  = dmtl_pkg::ST_PLACE;
            end
            dmtl_pkg::ST_PLACE: begin
                n_shown = r_below ? 4'd0 : w_shown;
                n_col   = w_start;
                n_glyph = '0;
                n_row   = '0;
                n_state = dmtl_pkg::ST_SCAN;
            end
            dmtl_pkg::ST_SCAN: begin
                if (r_glyph == r_shown) begin
                    n_state = dmtl_pkg::ST_FINISH;
                end else if (w_known_rd) begin
                    n_row   = '0;
                    n_state = dmtl_pkg::ST_EMIT;
                end else begin
                    n_glyph = r_glyph + 4'd1;
                    n_col   = r_col + dmtl_pkg::PITCH;
                end
            end
            dmtl_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    if (r_row == dmtl_pkg::LAST_ROW) begin
                        n_glyph = r_glyph + 4'd1;
                        n_col   = r_col + dmtl_pkg::PITCH;
                        n_state = dmtl_pkg::ST_SCAN;
                    end else begin
                        n_row = r_row + 3'd1;
                    end
                end
            end
            dmtl_pkg::ST_FINISH: begin
                n_len = '0;
                if (r_last) begin
                    n_index = '0;
                end else if (r_index < dmtl_pkg::INDEX_MAX) begin
                    n_index = r_index + 4'd1;
                end
                n_state = dmtl_pkg::ST_IDLE;
            end
            default: begin
                n_state = dmtl_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: holds a beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data.lamp_row     <= w_row_sum[5:0];
            r_out_data.first_column <= r_col;
            r_out_data.dot_mask     <= w_rows_rd[r_row] & w_keep;
            r_out_data.run_last     <= (r_row == dmtl_pkg::LAST_ROW) && !w_more;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The fill count never passes the buffer depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length beyond buffer depth");

    // The glyph pointer stays within the shown glyphs while scanning or drawing.
    a_glyph_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmtl_pkg::ST_SCAN || r_state == dmtl_pkg::ST_EMIT) |->
        r_glyph <= r_shown)
        else $error("glyph pointer past shown glyphs");

    // Rows are only drawn for glyphs that are shown.
    a_emit_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmtl_pkg::ST_EMIT) |-> (r_glyph < r_shown) && (r_row <= dmtl_pkg::LAST_ROW))
        else $error("row drawn outside the shown glyphs");

    // Closing a line always empties it before the next character is taken.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmtl_pkg::ST_FINISH) |=> (r_len == 4'd0) && (r_state == dmtl_pkg::ST_IDLE))
        else $error("line not cleared after flush");

    // Codes without a glyph carry no lit dots.
    a_unknown_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_known_wr |-> (w_rows_wr == '0))
        else $error("unknown code with lit dots");

endmodule

`default_nettype wire

// File: hdl/dmtl_font.sv
`timescale 1ns / 1ps
`default_nettype none

module dmtl_font (
    input  wire logic [7:0]           i_code,
    output      logic                 o_known,
    output      dmtl_pkg::t_glyph_rows o_rows
);

    logic [7:0] w_folded;

    function automatic dmtl_pkg::t_glyph_rows pack7(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6
    );
        dmtl_pkg::t_glyph_rows g;
        g[0] = r0; g[1] = r1; g[2] = r2; g[3] = r3;
        g[4] = r4; g[5] = r5; g[6] = r6;
        return g;
    endfunction

    // Lower case letters share the upper case glyphs.
    assign w_folded = (i_code >= 8'h61 && i_code <= 8'h7A) ? i_code - 8'd32 : i_code;

    // Glyph table lookup.
    always_comb begin
        o_known = 1'b1;
        case (w_folded)
            8'h20: o_rows = pack7(5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00);
            8'h41: o_rows = pack7(5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11);
            8'h42: o_rows = pack7(5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E);
            8'h43: o_rows = pack7(5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E);
            8'h44: o_rows = pack7(5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C);
            8'h45: o_rows = pack7(5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F);
            8'h46: o_rows = pack7(5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10);
            8'h47: o_rows = pack7(5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F);
            8'h48: o_rows = pack7(5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11);
            8'h49: o_rows = pack7(5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E);
            8'h4A: o_rows = pack7(5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C);
            8'h4B: o_rows = pack7(5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11);
            8'h4C: o_rows = pack7(5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F);
            8'h4D: o_rows = pack7(5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11);
            8'h4E: o_rows = pack7(5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11);
            8'h4F: o_rows = pack7(5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E);
            8'h50: o_rows = pack7(5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10);
            8'h51: o_rows = pack7(5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D);
            8'h52: o_rows = pack7(5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11);
            8'h53: o_rows = pack7(5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E);
            8'h54: o_rows = pack7(5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04);
            8'h55: o_rows = pack7(5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E);
            8'h56: o_rows = pack7(5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04);
            8'h57: o_rows = pack7(5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A);
            8'h58: o_rows = pack7(5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11);
            8'h59: o_rows = pack7(5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04);
            8'h5A: o_rows = pack7(5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F);
            8'h30: o_rows = pack7(5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E);
            8'h31: o_rows = pack7(5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E);
            8'h32: o_rows = pack7(5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F);
            8'h33: o_rows = pack7(5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E);
            8'h34: o_rows = pack7(5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02);
            8'h35: o_rows = pack7(5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E);
            8'h36: o_rows = pack7(5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E);
            8'h37: o_rows = pack7(5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08);
            8'h38: o_rows = pack7(5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E);
            8'h39: o_rows = pack7(5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C);
            8'h2E: o_rows = pack7(5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C);
            8'h2C: o_rows = pack7(5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08);
            8'h3A: o_rows = pack7(5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00);
            8'h2D: o_rows = pack7(5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00);
            8'h21: o_rows = pack7(5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04);
            8'h3F: o_rows = pack7(5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04);
            8'h2F: o_rows = pack7(5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10);
            8'h27: o_rows = pack7(5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00);
            8'h28: o_rows = pack7(5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02);
            8'h29: o_rows = pack7(5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08);
            8'h3E: o_rows = pack7(5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08);
            8'h3C: o_rows = pack7(5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02);
            8'h2B: o_rows = pack7(5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00);
            8'h3D: o_rows = pack7(5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00);
            8'h26: o_rows = pack7(5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D);
            8'h2A: o_rows = pack7(5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00);
            default: begin
                o_known = 1'b0;
                o_rows  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
